// ===== rtl/core/gmls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmls_pkg
// Shared types, register indexes and datapath operation codes of the grid
// mean luma site detector.
// ----------------------------------------------------------------------------
package gmls_pkg;

  localparam int CFG_W   = 13;
  localparam int LUMA_W  = 8;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 25;
  localparam int Q16_W   = 16;
  localparam int IDX_W   = 24;
  localparam int DIVN_W  = 40;
  localparam int DIVD_W  = 25;
  localparam int CIDX_W  = 3;

  typedef logic [CIDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FRAME_WIDTH   = 3'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT  = 3'd1;
  localparam cfg_idx_t REG_GRID_ROWS     = 3'd2;
  localparam cfg_idx_t REG_GRID_COLS     = 3'd3;
  localparam cfg_idx_t REG_THRESHOLD_Q8  = 3'd4;
  localparam cfg_idx_t REG_SITE_CAPACITY = 3'd5;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic              frame_start;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] site_index;
    logic [Q16_W-1:0] mean_q8;
    logic             frame_done;
    logic [Q16_W-1:0] sites_found;
    logic             overflow;
    logic             last;
  } out_item_t;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_LOAD      = 5'd1;
  localparam op_t OP_PREP      = 5'd2;
  localparam op_t OP_NUMC      = 5'd3;
  localparam op_t OP_DIVC_GO   = 5'd4;
  localparam op_t OP_DIVC_WAIT = 5'd5;
  localparam op_t OP_NUMR      = 5'd6;
  localparam op_t OP_DIVR_GO   = 5'd7;
  localparam op_t OP_DIVR_WAIT = 5'd8;
  localparam op_t OP_MC1       = 5'd9;
  localparam op_t OP_MC2       = 5'd10;
  localparam op_t OP_MR1       = 5'd11;
  localparam op_t OP_MR2       = 5'd12;
  localparam op_t OP_RD        = 5'd13;
  localparam op_t OP_ACC       = 5'd14;
  localparam op_t OP_TEST      = 5'd15;
  localparam op_t OP_DEC       = 5'd16;
  localparam op_t OP_DIVM_GO   = 5'd17;
  localparam op_t OP_DIVM_WAIT = 5'd18;
  localparam op_t OP_SITE      = 5'd19;
  localparam op_t OP_SUMM      = 5'd20;
  localparam op_t OP_ADV       = 5'd21;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_end;
    logic emit;
    logic is_last;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/core/grid_mean_luma_sparse_sites.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_mean_luma_sparse_sites
// Block-average luma over a grid of cells, emitting cells above a threshold.
// ----------------------------------------------------------------------------
// Pixels enter on in_item (luma, frame_start) in raster order; a transaction
// completes when in_valid is high and in_stall is low. Results leave on
// out_item under out_valid / out_stall: at most one site and one end-of-frame
// summary per pixel, the site first, last set on the final one.
// Configuration is written through cfg_valid / cfg_ready (always ready) with
// cfg_index selecting the register; write only while the block is idle.
// One pixel is handled at a time. Two divisions in the shared restoring
// divider locate the column and row cell, and further steps go to loading,
// wrap handling, boundary tests, the memory read-modify-write and the
// position update. The last pixel of a cell adds the threshold test; an
// emitted site adds a mean division and the output handoff; a summary adds
// its own output handoff.
// A stalled output holds the sequencer in its wait state until the result
// is taken.
// After the synchronous reset the registers take their defaults and the
// position and frame counters clear; the accumulator memory needs no clearing
// since each band restarts its entries before they are read.
// ----------------------------------------------------------------------------
module grid_mean_luma_sparse_sites #(
  parameter int MAX_COLS = 4096,
  parameter int MAX_DIM  = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gmls_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gmls_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  gmls_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]         cfg_data
);

  gmls_pkg::cmd_t    cmd;
  gmls_pkg::status_t status;

  assign cfg_ready = 1'b1;

  gmls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gmls_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_DIM  (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/gmls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmls_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gmls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic             rd_en,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/gmls_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmls_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gmls_div #(
  parameter int NUMW = 40,
  parameter int DENW = 25
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quot
);

  localparam int CTW = $clog2(NUMW + 1);

  logic [CTW-1:0]  cnt;
  logic            run;
  logic [DENW-1:0] rem;
  logic [DENW-1:0] dvs;
  logic [DENW:0]   shifted;
  logic            fits;

  assign shifted = {rem, quot[NUMW-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CTW'(NUMW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dvs  <= den;
    end else if (run) begin
      rem  <= fits ? DENW'(shifted - {1'b0, dvs}) : DENW'(shifted);
      quot <= {quot[NUMW-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/gmls_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmls_dp
// Datapath: configuration registers, raster position, cell geometry, column
// accumulator memory, threshold test, mean divider and output register.
// ----------------------------------------------------------------------------
module gmls_dp #(
  parameter int MAX_COLS = 4096,
  parameter int MAX_DIM  = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gmls_pkg::cmd_t              cmd,
  output gmls_pkg::status_t           status,
  input  gmls_pkg::in_item_t          in_item,
  input  logic                        cfg_we,
  input  gmls_pkg::cfg_idx_t          cfg_index,
  input  logic [31:0]                 cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output gmls_pkg::out_item_t         out_item
);

  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int NW  = (DW > CW) ? DW : CW;
  localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int PW  = 2 * NW + 2;
  localparam int SW  = gmls_pkg::SUM_W;
  localparam int KW  = gmls_pkg::CNT_W;
  localparam int QW  = gmls_pkg::Q16_W;

  // Configuration registers.
  logic [gmls_pkg::CFG_W-1:0] frame_width, frame_height, row_cells, col_cells;
  logic [QW-1:0]              threshold_q8, site_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 13'd640;
      frame_height  <= 13'd480;
      row_cells     <= 13'd0;
      col_cells     <= 13'd0;
      threshold_q8  <= 16'd0;
      site_capacity <= 16'd65535;
    end else if (cfg_we) begin
      case (cfg_index)
        gmls_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data[12:0];
        gmls_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data[12:0];
        gmls_pkg::REG_GRID_ROWS:     row_cells     <= cfg_data[12:0];
        gmls_pkg::REG_GRID_COLS:     col_cells     <= cfg_data[12:0];
        gmls_pkg::REG_THRESHOLD_Q8:  threshold_q8  <= cfg_data[15:0];
        gmls_pkg::REG_SITE_CAPACITY: site_capacity <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: a zero frame size acts as one, a zero grid count takes the frame size, large values saturate.
  logic [NW-1:0] w_eff, h_eff, r_eff, c_eff;
  logic [13:0]   c_raw;

  always_comb begin
    if (frame_width == '0) w_eff = NW'(1);
    else if (32'(frame_width) > MAX_DIM) w_eff = NW'(MAX_DIM);
    else w_eff = NW'(frame_width);

    if (frame_height == '0) h_eff = NW'(1);
    else if (32'(frame_height) > MAX_DIM) h_eff = NW'(MAX_DIM);
    else h_eff = NW'(frame_height);

    if (row_cells == '0) r_eff = h_eff;
    else if (32'(row_cells) > MAX_DIM) r_eff = NW'(MAX_DIM);
    else r_eff = NW'(row_cells);

    c_raw = (col_cells == '0) ? 14'(w_eff) : 14'(col_cells);
    if (32'(c_raw) > MAX_COLS) c_eff = NW'(MAX_COLS);
    else c_eff = NW'(c_raw);
  end

  // Pixel state.
  logic [NW-1:0]          x, y;
  logic [QW-1:0]          site_count;
  logic                   overflowed;
  logic [7:0]             luma;
  logic                   frame_start;
  logic [AW-1:0]          c_q;
  logic [NW-1:0]          r_q;
  logic [PW-1:0]          numer, pa, pb;
  logic                   st_c, en_c, st_r, en_r;
  logic [SW-1:0]          sum_q;
  logic [KW-1:0]          cnt_q;
  logic [SW+7:0]          s256_q;
  logic [SW+8:0]          thrn_q;
  logic [PW-1:0]          idx_q;

  // Restart and wrap handling before the pixel is placed.
  logic [NW:0]            xa, ya;
  logic [QW-1:0]          sca;
  logic                   ova;

  always_comb begin
    xa  = frame_start ? '0 : {1'b0, x};
    ya  = frame_start ? '0 : {1'b0, y};
    sca = frame_start ? '0 : site_count;
    ova = frame_start ? 1'b0 : overflowed;
    if (xa >= {1'b0, w_eff}) begin
      xa = '0;
      ya = ya + 1'b1;
    end
    if (ya >= {1'b0, h_eff}) begin
      ya  = '0;
      sca = '0;
      ova = 1'b0;
    end
  end

  logic is_last;
  assign is_last = (x == w_eff - 1'b1) && (y == h_eff - 1'b1);

  // Shared divider.
  logic                          div_start, div_done;
  logic [gmls_pkg::DIVN_W-1:0]   div_num, div_quot;
  logic [gmls_pkg::DIVD_W-1:0]   div_den;

  always_comb begin
    div_start = 1'b0;
    div_num   = gmls_pkg::DIVN_W'(numer);
    div_den   = gmls_pkg::DIVD_W'(w_eff);
    case (cmd.op)
      gmls_pkg::OP_DIVC_GO: begin
        div_start = 1'b1;
      end
      gmls_pkg::OP_DIVR_GO: begin
        div_start = 1'b1;
        div_den   = gmls_pkg::DIVD_W'(h_eff);
      end
      gmls_pkg::OP_DIVM_GO: begin
        div_start = 1'b1;
        div_num   = s256_q;
        div_den   = cnt_q;
      end
      default: ;
    endcase
  end

  gmls_div #(
    .NUMW (gmls_pkg::DIVN_W),
    .DENW (gmls_pkg::DIVD_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Column accumulator memory: sum in the upper bits, count below.
  logic              ram_we, ram_re;
  logic [SW+KW-1:0]  ram_wdata, ram_rdata;
  logic [SW-1:0]     base_sum, new_sum;
  logic [KW-1:0]     base_cnt, new_cnt;

  assign ram_re    = (cmd.op == gmls_pkg::OP_RD);
  assign ram_we    = (cmd.op == gmls_pkg::OP_ACC);
  assign base_sum  = (st_c && st_r) ? '0 : ram_rdata[SW+KW-1:KW];
  assign base_cnt  = (st_c && st_r) ? '0 : ram_rdata[KW-1:0];
  assign new_sum   = base_sum + SW'(luma);
  assign new_cnt   = base_cnt + 1'b1;
  assign ram_wdata = {new_sum, new_cnt};

  gmls_ram #(
    .WIDTH (SW + KW),
    .DEPTH (MAX_COLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .rd_en   (ram_re),
    .addr    (c_q),
    .wr_data (ram_wdata),
    .rd_data (ram_rdata)
  );

  logic qualify, room;
  assign qualify = (cnt_q != '0) && ({1'b0, s256_q} > thrn_q) && !overflowed;
  assign room    = (site_count < site_capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      x          <= '0;
      y          <= '0;
      site_count <= '0;
      overflowed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        gmls_pkg::OP_PREP: begin
          x          <= NW'(xa);
          y          <= NW'(ya);
          site_count <= sca;
          overflowed <= ova;
        end
        gmls_pkg::OP_DEC: begin
          if (qualify && !room) begin
            overflowed <= 1'b1;
          end
        end
        gmls_pkg::OP_SITE: begin
          site_count <= site_count + 1'b1;
          out_valid  <= 1'b1;
        end
        gmls_pkg::OP_SUMM: begin
          out_valid <= 1'b1;
        end
        gmls_pkg::OP_ADV: begin
          if (is_last) begin
            x          <= '0;
            y          <= '0;
            site_count <= '0;
            overflowed <= 1'b0;
          end else if (x + 1'b1 >= w_eff) begin
            x <= '0;
            y <= y + 1'b1;
          end else begin
            x <= x + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    case (cmd.op)
      gmls_pkg::OP_LOAD: begin
        luma        <= in_item.luma;
        frame_start <= in_item.frame_start;
      end
      gmls_pkg::OP_NUMC: numer <= PW'(PW'(x) + 1'b1) * PW'(c_eff) - 1'b1;
      gmls_pkg::OP_DIVC_WAIT: begin
        if (div_done) c_q <= AW'(div_quot);
      end
      gmls_pkg::OP_NUMR: numer <= PW'(PW'(y) + 1'b1) * PW'(r_eff) - 1'b1;
      gmls_pkg::OP_DIVR_WAIT: begin
        if (div_done) r_q <= NW'(div_quot);
      end
      gmls_pkg::OP_MC1: begin
        pa <= PW'(x) * PW'(c_eff);
        pb <= PW'(c_q) * PW'(w_eff);
      end
      gmls_pkg::OP_MC2: begin
        st_c <= (pa <= pb);
        pa   <= (PW'(x) + PW'(2)) * PW'(c_eff);
        pb   <= (PW'(c_q) + 1'b1) * PW'(w_eff);
      end
      gmls_pkg::OP_MR1: begin
        en_c <= (pb < pa);
        pa   <= PW'(y) * PW'(r_eff);
        pb   <= PW'(r_q) * PW'(h_eff);
      end
      gmls_pkg::OP_MR2: begin
        st_r <= (pa <= pb);
        pa   <= (PW'(y) + PW'(2)) * PW'(r_eff);
        pb   <= (PW'(r_q) + 1'b1) * PW'(h_eff);
      end
      gmls_pkg::OP_RD: en_r <= (pb < pa);
      gmls_pkg::OP_ACC: begin
        sum_q <= new_sum;
        cnt_q <= new_cnt;
      end
      gmls_pkg::OP_TEST: begin
        s256_q <= {sum_q, 8'h00};
        thrn_q <= (SW+9)'(threshold_q8) * (SW+9)'(cnt_q);
        idx_q  <= PW'(r_q) * PW'(c_eff) + PW'(c_q);
      end
      gmls_pkg::OP_SITE: begin
        out_item.site_index  <= gmls_pkg::IDX_W'(idx_q);
        out_item.mean_q8     <= div_quot[QW-1:0];
        out_item.frame_done  <= 1'b0;
        out_item.sites_found <= '0;
        out_item.overflow    <= 1'b0;
        out_item.last        <= !is_last;
      end
      gmls_pkg::OP_SUMM: begin
        out_item.site_index  <= '0;
        out_item.mean_q8     <= '0;
        out_item.frame_done  <= 1'b1;
        out_item.sites_found <= site_count;
        out_item.overflow    <= overflowed;
        out_item.last        <= 1'b1;
      end
      default: ;
    endcase
  end

  assign status.div_done = div_done;
  assign status.is_end   = en_c && en_r;
  assign status.emit     = qualify && room;
  assign status.is_last  = is_last;
  assign status.out_busy = out_valid;

`ifndef NO_ASSERTIONS
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == gmls_pkg::OP_NUMC) |-> (x < w_eff) && (y < h_eff))
    else $error("position outside frame after wrap handling");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == gmls_pkg::OP_MC1) |-> (NW'(c_q) < c_eff))
    else $error("column cell beyond grid");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.frame_done) |-> out_item.last)
    else $error("summary is not marked last");

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == gmls_pkg::OP_SITE || cmd.op == gmls_pkg::OP_SUMM) |-> !out_valid)
    else $error("output register overwritten");
`endif

endmodule

// ===== rtl/core/gmls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmls_ctrl
// Sequencer that walks one pixel through the datapath steps.
// ----------------------------------------------------------------------------
module gmls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  gmls_pkg::status_t status,
  output gmls_pkg::cmd_t    cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_PREP      = 5'd1;
  localparam logic [4:0] S_NUMC      = 5'd2;
  localparam logic [4:0] S_DIVC_GO   = 5'd3;
  localparam logic [4:0] S_DIVC_WAIT = 5'd4;
  localparam logic [4:0] S_NUMR      = 5'd5;
  localparam logic [4:0] S_DIVR_GO   = 5'd6;
  localparam logic [4:0] S_DIVR_WAIT = 5'd7;
  localparam logic [4:0] S_MC1       = 5'd8;
  localparam logic [4:0] S_MC2       = 5'd9;
  localparam logic [4:0] S_MR1       = 5'd10;
  localparam logic [4:0] S_MR2       = 5'd11;
  localparam logic [4:0] S_RD        = 5'd12;
  localparam logic [4:0] S_ACC       = 5'd13;
  localparam logic [4:0] S_TEST      = 5'd14;
  localparam logic [4:0] S_DEC       = 5'd15;
  localparam logic [4:0] S_DIVM_GO   = 5'd16;
  localparam logic [4:0] S_DIVM_WAIT = 5'd17;
  localparam logic [4:0] S_SITE      = 5'd18;
  localparam logic [4:0] S_WSITE     = 5'd19;
  localparam logic [4:0] S_CHK       = 5'd20;
  localparam logic [4:0] S_SUMM      = 5'd21;
  localparam logic [4:0] S_WSUM      = 5'd22;
  localparam logic [4:0] S_ADV       = 5'd23;

  logic [4:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = gmls_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = gmls_pkg::OP_LOAD;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op = gmls_pkg::OP_PREP;
        state_next = S_NUMC;
      end
      S_NUMC: begin
        cmd.op = gmls_pkg::OP_NUMC;
        state_next = S_DIVC_GO;
      end
      S_DIVC_GO: begin
        cmd.op = gmls_pkg::OP_DIVC_GO;
        state_next = S_DIVC_WAIT;
      end
      S_DIVC_WAIT: begin
        cmd.op = gmls_pkg::OP_DIVC_WAIT;
        if (status.div_done) state_next = S_NUMR;
      end
      S_NUMR: begin
        cmd.op = gmls_pkg::OP_NUMR;
        state_next = S_DIVR_GO;
      end
      S_DIVR_GO: begin
        cmd.op = gmls_pkg::OP_DIVR_GO;
        state_next = S_DIVR_WAIT;
      end
      S_DIVR_WAIT: begin
        cmd.op = gmls_pkg::OP_DIVR_WAIT;
        if (status.div_done) state_next = S_MC1;
      end
      S_MC1: begin
        cmd.op = gmls_pkg::OP_MC1;
        state_next = S_MC2;
      end
      S_MC2: begin
        cmd.op = gmls_pkg::OP_MC2;
        state_next = S_MR1;
      end
      S_MR1: begin
        cmd.op = gmls_pkg::OP_MR1;
        state_next = S_MR2;
      end
      S_MR2: begin
        cmd.op = gmls_pkg::OP_MR2;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.op = gmls_pkg::OP_RD;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = gmls_pkg::OP_ACC;
        state_next = status.is_end ? S_TEST : S_CHK;
      end
      S_TEST: begin
        cmd.op = gmls_pkg::OP_TEST;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.op = gmls_pkg::OP_DEC;
        state_next = status.emit ? S_DIVM_GO : S_CHK;
      end
      S_DIVM_GO: begin
        cmd.op = gmls_pkg::OP_DIVM_GO;
        state_next = S_DIVM_WAIT;
      end
      S_DIVM_WAIT: begin
        cmd.op = gmls_pkg::OP_DIVM_WAIT;
        if (status.div_done) state_next = S_SITE;
      end
      S_SITE: begin
        cmd.op = gmls_pkg::OP_SITE;
        state_next = S_WSITE;
      end
      S_WSITE: begin
        if (!status.out_busy) state_next = S_CHK;
      end
      S_CHK: begin
        state_next = status.is_last ? S_SUMM : S_ADV;
      end
      S_SUMM: begin
        cmd.op = gmls_pkg::OP_SUMM;
        state_next = S_WSUM;
      end
      S_WSUM: begin
        if (!status.out_busy) state_next = S_ADV;
      end
      S_ADV: begin
        cmd.op = gmls_pkg::OP_ADV;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP) |-> in_stall)
    else $error("input taken while a pixel is in work");

  a_load_once: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == gmls_pkg::OP_LOAD) |=> (state == S_PREP))
    else $error("load did not start the pixel sequence");

  a_wait_output: assert property (@(posedge clk) disable iff (rst)
    (state == S_WSITE && status.out_busy) |=> (state == S_WSITE))
    else $error("left site wait with output pending");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid mean luma site detector.
// ----------------------------------------------------------------------------
// Mostly small frame geometries are programmed between phases while the block is
// idle. Pixels are streamed from a queue with random gaps and random output
// stalls. Every accepted pixel is run through a cycle-free model of the cell
// accumulation, and the sites and frame summaries it predicts are compared
// field by field with what the block delivers.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int GRID_MAX     = 4096;
  localparam int DRAIN_CYCLES = 400;
  localparam int WATCHDOG     = 20000;
  localparam int RAND_ITEMS   = 1750;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  gmls_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  gmls_pkg::out_item_t out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  gmls_pkg::cfg_idx_t  cfg_index;
  logic [31:0]         cfg_data;

  grid_mean_luma_sparse_sites dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gmls_pkg::in_item_t  pixel_q[$];
  gmls_pkg::out_item_t site_q[$];
  int        errors = 0;
  int        idle_pct;
  int        quiet_cycles;

  // Shadow registers and geometry state of the detector.
  int unsigned m_width, m_height, m_rows, m_cols, m_thr, m_cap;
  int unsigned m_x, m_y, m_site_count;
  bit          m_ovf;
  bit [31:0]   m_sum[GRID_MAX];
  bit [24:0]   m_cnt[GRID_MAX];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned clamp_dim(longint unsigned v);
    if (v == 0) return 1;
    return (v > GRID_MAX) ? GRID_MAX : v;
  endfunction

  function automatic void shadow_reset();
    m_width = 640;  m_height = 480;  m_rows = 0;  m_cols = 0;
    m_thr = 0;  m_cap = 65535;
    m_x = 0;  m_y = 0;  m_site_count = 0;  m_ovf = 1'b0;
  endfunction

  function automatic void shadow_write(gmls_pkg::cfg_idx_t idx, logic [31:0] val);
    case (idx)
      gmls_pkg::REG_FRAME_WIDTH:   m_width  = val[12:0];
      gmls_pkg::REG_FRAME_HEIGHT:  m_height = val[12:0];
      gmls_pkg::REG_GRID_ROWS:     m_rows   = val[12:0];
      gmls_pkg::REG_GRID_COLS:     m_cols   = val[12:0];
      gmls_pkg::REG_THRESHOLD_Q8:  m_thr    = val[15:0];
      gmls_pkg::REG_SITE_CAPACITY: m_cap    = val[15:0];
      default: ;
    endcase
  endfunction

  // Accumulate one pixel into its cell and queue the sites and summary it yields.
  function automatic void accumulate_pixel(gmls_pkg::in_item_t px);
    longint unsigned w, h, nr, nc, x, y, r, c, n, s256;
    gmls_pkg::out_item_t site, summ;
    bit        have_site;
    w = clamp_dim(m_width);
    h = clamp_dim(m_height);
    nr = (m_rows != 0) ? clamp_dim(m_rows) : h;
    nc = (m_cols != 0) ? m_cols : w;
    if (nc > GRID_MAX) nc = GRID_MAX;
    have_site = 1'b0;
    site = '0;
    summ = '0;
    if (px.frame_start) begin
      m_x = 0;  m_y = 0;  m_site_count = 0;  m_ovf = 1'b0;
    end
    if (m_x >= w) begin
      m_x = 0;  m_y++;
    end
    if (m_y >= h) begin
      m_y = 0;  m_site_count = 0;  m_ovf = 1'b0;
    end
    x = m_x;
    y = m_y;
    r = ((y + 1) * nr - 1) / h;
    c = ((x + 1) * nc - 1) / w;
    if (c < GRID_MAX) begin
      if (x == (c * w) / nc && y == (r * h) / nr) begin
        m_sum[c] = '0;
        m_cnt[c] = '0;
      end
      m_sum[c] = m_sum[c] + px.luma;
      m_cnt[c] = m_cnt[c] + 1'b1;
      if (x + 1 == ((c + 1) * w) / nc && y + 1 == ((r + 1) * h) / nr) begin
        n = m_cnt[c];
        s256 = longint'(m_sum[c]) * 256;
        if (n != 0 && s256 > longint'(m_thr) * n && !m_ovf) begin
          if (m_site_count < m_cap) begin
            site.site_index = gmls_pkg::IDX_W'(r * nc + c);
            site.mean_q8 = gmls_pkg::Q16_W'(s256 / n);
            site.last = 1'b1;
            have_site = 1'b1;
            m_site_count = (m_site_count + 1) & 16'hFFFF;
          end else begin
            m_ovf = 1'b1;
          end
        end
      end
    end
    if (x == w - 1 && y == h - 1) begin
      site.last = 1'b0;
      summ.frame_done = 1'b1;
      summ.sites_found = gmls_pkg::Q16_W'(m_site_count);
      summ.overflow = m_ovf;
      summ.last = 1'b1;
      if (have_site) site_q.push_back(site);
      site_q.push_back(summ);
      m_x = 0;  m_y = 0;  m_site_count = 0;  m_ovf = 1'b0;
    end else begin
      if (have_site) site_q.push_back(site);
      m_x++;
      if (m_x >= w) begin
        m_x = 0;  m_y++;
      end
    end
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Driver: when no transaction is held, offers the next queued pixel or, at random, leaves a gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) accumulate_pixel(in_item);
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_item  <= pixel_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each delivered result and keeps the watchdog.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (site_q.size() == 0) begin
          report_mismatch("unexpected_result", 1, 0);
        end else begin
          gmls_pkg::out_item_t want;
          want = site_q.pop_front();
          if (out_item.site_index != want.site_index)
            report_mismatch("site_index", out_item.site_index, want.site_index);
          if (out_item.mean_q8 != want.mean_q8)
            report_mismatch("mean_q8", out_item.mean_q8, want.mean_q8);
          if (out_item.frame_done != want.frame_done)
            report_mismatch("frame_done", out_item.frame_done, want.frame_done);
          if (out_item.sites_found != want.sites_found)
            report_mismatch("sites_found", out_item.sites_found, want.sites_found);
          if (out_item.overflow != want.overflow)
            report_mismatch("overflow", out_item.overflow, want.overflow);
          if (out_item.last != want.last)
            report_mismatch("last", out_item.last, want.last);
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
        $display("grid_mean_luma_sparse_sites verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(gmls_pkg::cfg_idx_t idx, int unsigned val, int bits);
    logic [31:0] word;
    word = $urandom;
    word = (word << bits) | (val & ((32'd1 << bits) - 1));
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, word);
  endtask

  task automatic program_grid(int unsigned w, int unsigned h, int unsigned nr,
                              int unsigned nc, int unsigned thr, int unsigned cap);
    write_reg(gmls_pkg::REG_FRAME_WIDTH, w, gmls_pkg::CFG_W);
    write_reg(gmls_pkg::REG_FRAME_HEIGHT, h, gmls_pkg::CFG_W);
    write_reg(gmls_pkg::REG_GRID_ROWS, nr, gmls_pkg::CFG_W);
    write_reg(gmls_pkg::REG_GRID_COLS, nc, gmls_pkg::CFG_W);
    write_reg(gmls_pkg::REG_THRESHOLD_Q8, thr, gmls_pkg::Q16_W);
    write_reg(gmls_pkg::REG_SITE_CAPACITY, cap, gmls_pkg::Q16_W);
    cfg_valid <= 1'b0;
  endtask

  function automatic void queue_pixel(int unsigned luma, bit fs);
    gmls_pkg::in_item_t px;
    px.luma = gmls_pkg::LUMA_W'(luma);
    px.frame_start = fs;
    pixel_q.push_back(px);
  endfunction

  function automatic int unsigned pick_luma();
    case ($urandom_range(7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // An item can finish without a result, so the block gets extra time to settle.
  task automatic drain();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_valid || site_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned w, h, nr, nc, thr, cap, frames;
    int total, phase;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = gmls_pkg::REG_FRAME_WIDTH;
    cfg_data = '0;
    idle_pct = 25;
    shadow_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One cell per pixel, extremes of luma, zero threshold.
    program_grid(4, 2, 0, 0, 0, 65535);
    queue_pixel(0, 1);  queue_pixel(255, 0);  queue_pixel(1, 0);  queue_pixel(128, 0);
    queue_pixel(255, 1);  queue_pixel(0, 0);  queue_pixel(254, 0);  queue_pixel(127, 0);
    drain();
    // Zero sizes act as one: one frame and summary per pixel; 255 adds a site.
    program_grid(0, 0, 0, 0, 65279, 65535);
    queue_pixel(255, 1);  queue_pixel(254, 0);  queue_pixel(255, 0);
    drain();
    // No capacity: the single qualifying cell overflows.
    program_grid(3, 2, 1, 1, 0, 0);
    for (int i = 0; i < 6; i++) queue_pixel(200, i == 0);
    drain();
    // Grid finer than the frame leaves empty cells.
    program_grid(2, 2, 4096, 4096, 100, 65535);
    for (int i = 0; i < 4; i++) queue_pixel(255 - i, i == 0);
    drain();
    // Oversized values saturate; a partial frame restarted in mid-frame.
    program_grid(8191, 8191, 8191, 5000, 65535, 65535);
    queue_pixel(255, 1);  queue_pixel(255, 0);  queue_pixel(0, 1);  queue_pixel(17, 0);
    drain();

    total = 0;
    phase = 0;
    while (total < RAND_ITEMS) begin
      idle_pct = (phase == 3) ? 0 : 25;
      w = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      case ($urandom_range(3))
        0: nr = 0;
        1: nr = $urandom_range(1, h);
        2: nr = $urandom_range(1, h + 3);
        default: nr = ($urandom_range(1)) ? 4096 : 1;
      endcase
      case ($urandom_range(3))
        0: nc = 0;
        1: nc = $urandom_range(1, w);
        2: nc = $urandom_range(1, w + 3);
        default: nc = ($urandom_range(1)) ? 4096 : 1;
      endcase
      case ($urandom_range(5))
        0: thr = 0;
        1: thr = 65535;
        default: thr = $urandom_range(65535);
      endcase
      cap = ($urandom_range(2) == 0) ? $urandom_range(0, 4) : 65535;
      program_grid(w, h, nr, nc, thr, cap);
      frames = (phase == 3) ? 300 / (w * h) + 1 : $urandom_range(2, 5);
      for (int f = 0; f < frames; f++) begin
        for (int p = 0; p < w * h; p++) begin
          bit fs;
          fs = (f == 0 && p == 0) || (p == 0 && $urandom_range(9) == 0)
               || $urandom_range(49) == 0;
          queue_pixel(pick_luma(), fs);
          total++;
        end
      end
      drain();
      phase++;
    end

    if (errors == 0) begin
      $display("grid_mean_luma_sparse_sites verification clean");
    end else begin
      $display("grid_mean_luma_sparse_sites verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/gmls_pkg.sv
rtl/core/gmls_ram.sv
rtl/core/gmls_div.sv
rtl/core/gmls_dp.sv
rtl/core/gmls_ctrl.sv
rtl/core/grid_mean_luma_sparse_sites.sv
tb/tb_top.sv
